/* src/bubble_sort_engine_core_macros.svh */
// assertion macros used by the checker
`ifndef BUBBLE_SORT_ENGINE_CORE_MACROS_SVH
`define BUBBLE_SORT_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define BSE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define BSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* src/bse_pkg.sv */
package bse_pkg;

   localparam int MAX_COUNT_DEF = 16;
   localparam int DATA_W        = 32;

   typedef logic signed [DATA_W-1:0] bse_data_type;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SORT = 3'b010,
      ST_EMIT = 3'b100
   } bse_state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_en;
      logic sort_en;
      logic phase;
      logic emit_en;
      logic emit_last;
      logic emit_ovf;
   } bse_cmd_type;

endpackage

/* src/bse_if.sv */
interface bse_req_if;
   import bse_pkg::*;
   logic         valid;
   logic         ready;
   bse_data_type value;
   logic         last;

   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface

interface bse_rsp_if;
   import bse_pkg::*;
   logic         valid;
   logic         ready;
   bse_data_type value_res;
   logic         last_res;
   logic         overflow;

   modport source (output valid, output value_res, output last_res, output overflow,
                   input ready);
   modport sink (input valid, input value_res, input last_res, input overflow,
                 output ready);
endinterface

/* src/bse_ctrl.sv */
module bse_ctrl #(
   parameter int MAX_COUNT = bse_pkg::MAX_COUNT_DEF,
   parameter int CNT_W     = $clog2(MAX_COUNT + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output bse_pkg::bse_cmd_type cmd,
   output logic [CNT_W-1:0]    count
);
   import bse_pkg::*;

   bse_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pass_ff, pass_in;
   logic             ovf_ff, ovf_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pass_in      = pass_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = (state_ff == ST_LOAD);
      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (count_ff == CNT_W'(MAX_COUNT)) begin
                  ovf_in = 1'b1;
               end else begin
                  cmd.load_en = 1'b1;
                  count_in    = count_ff + CNT_W'(1);
               end
               if (req_last) begin
                  state_in = ST_SORT;
                  pass_in  = '0;
               end
            end
         end
         ST_SORT: begin
            // one odd-even pass per cycle, count passes in all
            cmd.sort_en = 1'b1;
            cmd.phase   = pass_ff[0];
            pass_in     = pass_ff + CNT_W'(1);
            if (pass_ff == count_ff - CNT_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit_en   = 1'b1;
               cmd.emit_last = (count_ff == CNT_W'(1));
               cmd.emit_ovf  = ovf_ff;
               rsp_valid_in  = 1'b1;
               count_in      = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = ST_LOAD;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         pass_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pass_ff      <= pass_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign count     = count_ff;

endmodule

/* src/bse_dp.sv */
module bse_dp #(
   parameter int MAX_COUNT = bse_pkg::MAX_COUNT_DEF,
   parameter int CNT_W     = $clog2(MAX_COUNT + 1)
) (
   input  logic                 clock,
   input  bse_pkg::bse_cmd_type cmd,
   input  logic [CNT_W-1:0]     count,
   input  bse_pkg::bse_data_type value,
   output bse_pkg::bse_data_type value_res,
   output logic                 last_res,
   output logic                 overflow
);
   import bse_pkg::*;

   bse_data_type store_ff [MAX_COUNT];
   bse_data_type store_in [MAX_COUNT];
   bse_data_type value_res_ff;
   logic         last_res_ff;
   logic         overflow_ff;

   always_comb begin
      store_in = store_ff;
      if (cmd.load_en) begin
         for (int k = 0; k < MAX_COUNT; k++) begin
            if (count == CNT_W'(k)) begin
               store_in[k] = value;
            end
         end
      end else if (cmd.sort_en) begin
         // disjoint neighbour pairs, swap only on strictly less
         for (int k = 1; k < MAX_COUNT; k++) begin
            if (((k % 2) != int'(cmd.phase)) && (CNT_W'(k) < count) &&
                (store_ff[k] < store_ff[k-1])) begin
               store_in[k]   = store_ff[k-1];
               store_in[k-1] = store_ff[k];
            end
         end
      end else if (cmd.emit_en) begin
         // shift towards the head, head goes out
         for (int k = 0; k < MAX_COUNT - 1; k++) begin
            store_in[k] = store_ff[k+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
      if (cmd.emit_en) begin
         value_res_ff <= store_ff[0];
         last_res_ff  <= cmd.emit_last;
         overflow_ff  <= cmd.emit_ovf;
      end
   end

   assign value_res = value_res_ff;
   assign last_res  = last_res_ff;
   assign overflow  = overflow_ff;

endmodule

/* src/bubble_sort_engine_core.sv */
// sorting engine for signed 32-bit values: items arrive on req one value each
// and the item flagged last closes the set; the block then returns the set in
// ascending order on rsp, one value per item, last_res on the final one. equal
// values leave in arrival order. up to MAX_COUNT values are held; any further
// value is dropped and overflow is raised on every item of that set. a set of
// N values is loaded one item a cycle, put in order by N odd-even exchange
// passes over the register row, then emitted, holding while rsp is stalled;
// input is held off from the close of a set until its final result sits in
// the output register
module bubble_sort_engine_core #(
   parameter int MAX_COUNT = bse_pkg::MAX_COUNT_DEF
) (
   input logic      clock,
   input logic      reset,
   bse_req_if.sink  req,
   bse_rsp_if.source rsp
);
   import bse_pkg::*;

   // count must hold MAX_COUNT itself
   localparam int CNT_W = $clog2(MAX_COUNT + 1);

   bse_cmd_type      cmd;
   logic [CNT_W-1:0] count;

   // controller: load / sort / emit sequencing, counts and handshakes
   bse_ctrl #(
      .MAX_COUNT (MAX_COUNT),
      .CNT_W     (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.last),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .cmd       (cmd),
      .count     (count)
   );

   // datapath: register row with compare-exchange cells and output register
   bse_dp #(
      .MAX_COUNT (MAX_COUNT),
      .CNT_W     (CNT_W)
   ) u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .count     (count),
      .value     (req.value),
      .value_res (rsp.value_res),
      .last_res  (rsp.last_res),
      .overflow  (rsp.overflow)
   );

endmodule

/* src/bse_checker.sv */
`include "bubble_sort_engine_core_macros.svh"

module bse_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last_res
);

   // a stalled result stays offered
   `BSE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // no result straight out of reset
   `BSE_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid)

   // closing a set stops intake while it is ordered
   `BSE_ASSERT_NEXT(a_close_stall, clock, reset, req_valid && req_ready && req_last, !req_ready)

   // the end-of-set marker of a stalled result does not move
   `BSE_ASSERT_NEXT(a_last_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_last_res))

endmodule

bind bubble_sort_engine_core bse_checker u_bse_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .req_last     (req.last),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_last_res (rsp.last_res)
);
